/* hdl/nfpa_pkg.sv */
// Shared types and constants for the next-fit page allocator.
`default_nettype none

package nfpa_pkg;

	localparam int HEAP_PAGES = 4096;
	localparam int PG_W       = $clog2(HEAP_PAGES);
	localparam int CNT_W      = $clog2(HEAP_PAGES + 1);
	localparam int PAGE_SHIFT = 12;
	localparam int ADDR_W     = 32;
	localparam int BASE_W     = ADDR_W - PAGE_SHIFT;
	localparam int NEED_W     = ADDR_W + 1 - PAGE_SHIFT;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_ZERO    = 2'd2;
	localparam logic [1:0] ST_IGNORED = 2'd3;

	typedef struct packed {
		logic              req_type;
		logic [ADDR_W-1:0] size_bytes;
		logic [ADDR_W-1:0] free_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] block_address;
		logic [1:0]        status;
	} rsp_t;

	typedef struct packed {
		logic       load;
		logic       scan_init;
		logic       scan;
		logic       mark;
		logic       rl_read;
		logic       fstart;
		logic       fclr;
		logic       clr;
		logic       res_set;
		logic [1:0] res_status;
		logic       res_use_addr;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic is_free;
		logic size_zero;
		logic oversize;
		logic free_bad;
		logic hit;
		logic exhausted;
		logic left_one;
		logic fclr_last;
		logic rl_zero;
		logic wr_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

/* hdl/next_fit_page_allocator.sv */
// Top level of the next-fit contiguous page allocator.
//
//   channel  signals                    width  direction  moves
//   req      req_valid/req_stall/req     65     in         allocate or free request word
//   rsp      rsp_valid/rsp_stall/rsp     34     out        address and status word
//   cfg      cfg_we/cfg_wdata            20     in         heap base page, no read-back
//
// After reset a clearing pass sweeps both page memories, one page a cycle, with req_stall
// high; cfg writes are taken throughout.
// Allocate: decode and start, scan from the next-fit pointer (up to HEAP_PAGES pages),
// mark the pages of the run, then load the result; a lap with no fit ends the scan.
// Zero or oversized: decode, then load the result.
// Free: decode, read the run length, release its pages, then load the result; an address
// refused at decode goes straight to the result. One request is worked at a time; the
// bitmap memory has one write port and one read port, and is written one bit a cycle.
// A waiting result does not block acceptance of the next word, only its completion.
`default_nettype none

module next_fit_page_allocator (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire nfpa_pkg::req_t              req,
	output logic                             rsp_valid,
	input  wire logic                        rsp_stall,
	output nfpa_pkg::rsp_t                   rsp,
	input  wire logic                        cfg_we,
	input  wire logic [nfpa_pkg::BASE_W-1:0] cfg_wdata
);
	import nfpa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	nfpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	nfpa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

/* hdl/nfpa_ctrl.sv */
// Sequencer for the page allocator: clearing pass, request decode, scan, mark and free.
`default_nettype none

module nfpa_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire nfpa_pkg::sts_t sts,
	output nfpa_pkg::cmd_t      cmd
);
	import nfpa_pkg::*;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_DEC  = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_MARK = 3'd4;
	localparam logic [2:0] S_FRD  = 3'd5;
	localparam logic [2:0] S_FCLR = 3'd6;
	localparam logic [2:0] S_RESP = 3'd7;

	logic [2:0] st_q;
	logic [2:0] st_d;

	always_comb begin
		cmd       = '0;
		st_d      = st_q;
		req_stall = (st_q != S_IDLE);
		case (st_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				if (sts.wr_last) begin
					st_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					st_d     = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.is_free) begin
					if (sts.free_bad) begin
						cmd.res_set    = 1'b1;
						cmd.res_status = ST_IGNORED;
						st_d           = S_RESP;
					end else begin
						cmd.rl_read = 1'b1;
						st_d        = S_FRD;
					end
				end else if (sts.size_zero) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = ST_ZERO;
					st_d           = S_RESP;
				end else if (sts.oversize) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = ST_NOFIT;
					st_d           = S_RESP;
				end else begin
					cmd.scan_init = 1'b1;
					st_d          = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					st_d = S_MARK;
				end else if (sts.exhausted) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = ST_NOFIT;
					st_d           = S_RESP;
				end
			end
			S_MARK: begin
				cmd.mark = 1'b1;
				if (sts.left_one) begin
					cmd.res_set      = 1'b1;
					cmd.res_status   = ST_DONE;
					cmd.res_use_addr = 1'b1;
					st_d             = S_RESP;
				end
			end
			S_FRD: begin
				cmd.fstart = 1'b1;
				if (sts.rl_zero) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = ST_IGNORED;
					st_d           = S_RESP;
				end else begin
					st_d = S_FCLR;
				end
			end
			S_FCLR: begin
				cmd.fclr = 1'b1;
				if (sts.fclr_last) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = ST_DONE;
					st_d           = S_RESP;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					st_d         = S_IDLE;
				end
			end
			default: begin
				st_d = S_CLR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR;
		end else begin
			st_q <= st_d;
		end
	end

	// a finished request must reach the result stage before the next word is taken
	a_resp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_set |=> st_q == S_RESP)
		else $error("result not handed to response stage");

	a_mark_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_SCAN && sts.hit) |=> st_q == S_MARK)
		else $error("run found but marking did not start");

	a_clr_only_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != S_CLR |=> st_q != S_CLR)
		else $error("clearing pass re-entered");

endmodule

`default_nettype wire

/* hdl/nfpa_dp.sv */
// Datapath: page bitmap and run-length memories, scan pipeline, address maths, result register.
`default_nettype none

module nfpa_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire nfpa_pkg::cmd_t               cmd,
	output nfpa_pkg::sts_t                    sts,
	input  wire nfpa_pkg::req_t               req,
	input  wire logic                         cfg_we,
	input  wire logic [nfpa_pkg::BASE_W-1:0]  cfg_wdata,
	output logic                              rsp_valid,
	input  wire logic                         rsp_stall,
	output nfpa_pkg::rsp_t                    rsp
);
	import nfpa_pkg::*;

	localparam logic [PG_W-1:0]  LAST_PG  = PG_W'(HEAP_PAGES - 1);
	localparam logic [CNT_W-1:0] NPAGES   = CNT_W'(HEAP_PAGES);

	// storage
	logic             pu_mem [HEAP_PAGES];
	logic [CNT_W-1:0] rl_mem [HEAP_PAGES];

	logic [BASE_W-1:0] base_q;
	req_t              req_q;
	logic [PG_W-1:0]   next_search_q;

	// scan pipeline
	logic [PG_W-1:0]  iss_ptr_q;
	logic [CNT_W-1:0] iss_cnt_q;
	logic [CNT_W-1:0] proc_cnt_q;
	logic             v_s1;
	logic [PG_W-1:0]  pg_s1;
	logic             pu_rd_s1;
	logic [CNT_W-1:0] count_q;
	logic [PG_W-1:0]  first_q;
	logic [CNT_W-1:0] need_q;

	// write walker, shared by clearing pass, marking and freeing
	logic [PG_W-1:0]  wr_ptr_q;
	logic [CNT_W-1:0] left_q;

	logic [CNT_W-1:0] rl_rd_s1;

	logic [BASE_W-1:0] res_addr_pg_q;
	logic [1:0]        res_status_q;
	logic              out_valid_q;
	rsp_t              rsp_q;

	// decode of the held request
	logic [ADDR_W:0]     size_pad;
	logic [NEED_W-1:0]   need_w;
	logic [BASE_W-1:0]   addr_pg;
	logic [BASE_W:0]     pg_off;
	logic                in_range;
	logic                aligned;
	logic [PG_W-1:0]     idx;

	logic             iss_go;
	logic [CNT_W-1:0] cnt_inc;
	logic             hit;
	logic [PG_W-1:0]  first_nx;
	logic [PG_W-1:0]  iss_ptr_inc;
	logic [PG_W-1:0]  wr_ptr_inc;
	logic [CNT_W-1:0] nxt_sum;
	logic [BASE_W-1:0] alloc_pg;

	logic             pu_we;
	logic             pu_wd;
	logic             rl_we;
	logic [PG_W-1:0]  rl_wa;
	logic [CNT_W-1:0] rl_wd;

	assign size_pad = {1'b0, req_q.size_bytes} + (ADDR_W+1)'((1 << PAGE_SHIFT) - 1);
	assign need_w   = size_pad[ADDR_W:PAGE_SHIFT];
	assign addr_pg  = req_q.free_address[ADDR_W-1:PAGE_SHIFT];
	assign pg_off   = {1'b0, addr_pg} - {1'b0, base_q};
	assign in_range = (addr_pg >= base_q) && (pg_off < (BASE_W+1)'(HEAP_PAGES));
	assign aligned  = (req_q.free_address[PAGE_SHIFT-1:0] == '0);
	assign idx      = pg_off[PG_W-1:0];

	assign iss_go      = cmd.scan && (iss_cnt_q < NPAGES);
	assign cnt_inc     = count_q + 1'b1;
	assign hit         = cmd.scan && v_s1 && !pu_rd_s1 && (cnt_inc == need_q);
	assign first_nx    = (count_q == '0) ? pg_s1 : first_q;
	assign iss_ptr_inc = (iss_ptr_q == LAST_PG) ? '0 : iss_ptr_q + 1'b1;
	assign wr_ptr_inc  = (wr_ptr_q == LAST_PG) ? '0 : wr_ptr_q + 1'b1;
	assign nxt_sum     = CNT_W'(first_q) + need_q;
	assign alloc_pg    = base_q + BASE_W'(first_q);

	always_comb begin
		sts           = '0;
		sts.is_free   = (req_q.req_type == REQ_FREE);
		sts.size_zero = (req_q.size_bytes == '0);
		sts.oversize  = (need_w > NEED_W'(HEAP_PAGES));
		sts.free_bad  = !(in_range && aligned);
		sts.hit       = hit;
		sts.exhausted = (proc_cnt_q == NPAGES);
		sts.left_one  = (left_q == CNT_W'(1));
		sts.fclr_last = (left_q == CNT_W'(1)) || (wr_ptr_q == LAST_PG);
		sts.rl_zero   = (rl_rd_s1 == '0);
		sts.wr_last   = (wr_ptr_q == LAST_PG);
		sts.out_free  = !out_valid_q || !rsp_stall;
	end

	// memory write port selection
	always_comb begin
		pu_we = cmd.clr || cmd.mark || cmd.fclr;
		pu_wd = cmd.mark;
		rl_we = 1'b0;
		rl_wa = wr_ptr_q;
		rl_wd = '0;
		if (cmd.clr) begin
			rl_we = 1'b1;
		end else if (cmd.mark && sts.left_one) begin
			rl_we = 1'b1;
			rl_wa = first_q;
			rl_wd = need_q;
		end else if (cmd.fstart && !sts.rl_zero) begin
			rl_we = 1'b1;
			rl_wa = idx;
		end
	end

	always_ff @(posedge clk) begin
		if (pu_we) begin
			pu_mem[wr_ptr_q] <= pu_wd;
		end
		if (iss_go) begin
			pu_rd_s1 <= pu_mem[iss_ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (rl_we) begin
			rl_mem[rl_wa] <= rl_wd;
		end
		if (cmd.rl_read) begin
			rl_rd_s1 <= rl_mem[idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (iss_go) begin
			pg_s1 <= iss_ptr_q;
		end
		if (cmd.scan_init) begin
			need_q <= need_w[CNT_W-1:0];
		end
		if (cmd.out_load) begin
			rsp_q <= '{block_address: {res_addr_pg_q, {PAGE_SHIFT{1'b0}}},
				status: res_status_q};
		end
		if (cmd.res_set) begin
			res_status_q  <= cmd.res_status;
			res_addr_pg_q <= cmd.res_use_addr ? alloc_pg : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_ptr_q     <= '0;
			iss_cnt_q     <= '0;
			proc_cnt_q    <= '0;
			v_s1          <= 1'b0;
			count_q       <= '0;
			first_q       <= '0;
			wr_ptr_q      <= '0;
			left_q        <= '0;
			next_search_q <= '0;
		end else begin
			if (cmd.scan_init) begin
				iss_ptr_q  <= next_search_q;
				iss_cnt_q  <= '0;
				proc_cnt_q <= '0;
				v_s1       <= 1'b0;
				count_q    <= '0;
			end else if (cmd.scan) begin
				v_s1 <= iss_go;
				if (iss_go) begin
					iss_ptr_q <= iss_ptr_inc;
					iss_cnt_q <= iss_cnt_q + 1'b1;
				end
				if (v_s1) begin
					proc_cnt_q <= proc_cnt_q + 1'b1;
					if (pu_rd_s1) begin
						count_q <= '0;
					end else begin
						first_q <= first_nx;
						// a run never crosses the end of the heap
						count_q <= (pg_s1 == LAST_PG) ? '0 : cnt_inc;
					end
				end
			end

			if (hit) begin
				wr_ptr_q <= first_nx;
				left_q   <= need_q;
			end else if (cmd.clr || cmd.mark || cmd.fclr) begin
				wr_ptr_q <= wr_ptr_inc;
				left_q   <= left_q - 1'b1;
			end else if (cmd.fstart) begin
				wr_ptr_q <= idx;
				left_q   <= rl_rd_s1;
			end

			if (cmd.mark && sts.left_one) begin
				next_search_q <= (nxt_sum >= NPAGES) ? '0 : nxt_sum[PG_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

	a_walk_left: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mark || cmd.fclr) |-> left_q != '0)
		else $error("page walk with nothing left to write");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		iss_cnt_q <= NPAGES && proc_cnt_q <= iss_cnt_q)
		else $error("scan ran past one lap");

	a_run_below_need: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan && v_s1) |-> count_q < need_q)
		else $error("run count overtook the request");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && rsp_stall))
		else $error("result overwritten while still waiting");

endmodule

`default_nettype wire

/* dv/tb_next_fit_page_allocator.sv */
// Self-checking testbench for the next-fit page allocator: directed and random words.
`timescale 1ns / 100ps

module tb_next_fit_page_allocator;
	import nfpa_pkg::*;

	// worst case: every word a full scan plus a full mark, longest gap and stall, x3
	localparam int CYCLE_LIMIT = 4_000_000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	req_t              req = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	rsp_t              rsp;
	logic              cfg_we = 1'b0;
	logic [BASE_W-1:0] cfg_wdata = '0;

	next_fit_page_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// shadow allocator state
	bit                page_taken [HEAP_PAGES];
	int unsigned       run_len [HEAP_PAGES];
	int unsigned       roving = 0;
	logic [BASE_W-1:0] heap_base = '0;

	req_t        request_backlog [$];
	rsp_t        awaited_results [$];
	int unsigned live_pages [$];

	int    errors = 0;
	int    cycles = 0;
	int    gap = 0;
	int    stall_left = 0;
	bit    quiet = 1'b0;
	bit    launch;
	logic  req_taken = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic rsp_t allocator_result(req_t w);
		rsp_t              r;
		longint unsigned   need, lo, hi, addr;
		int unsigned       cur, cnt, first, k, idx;
		bit                hit;
		r.block_address = '0;
		r.status = ST_DONE;
		if (w.req_type == REQ_ALLOC) begin
			need = (longint'(w.size_bytes) + 4095) >> PAGE_SHIFT;
			if (w.size_bytes == 0) begin
				r.status = ST_ZERO;
			end else if (need > HEAP_PAGES) begin
				r.status = ST_NOFIT;
			end else begin
				cur = roving;
				cnt = 0;
				first = 0;
				hit = 1'b0;
				for (k = 0; k < HEAP_PAGES && !hit; k++) begin
					if (!page_taken[cur]) begin
						if (cnt == 0)
							first = cur;
						cnt++;
						if (cnt == need)
							hit = 1'b1;
					end else begin
						cnt = 0;
					end
					// a run may not cross the top of the heap
					if (!hit) begin
						cur++;
						if (cur >= HEAP_PAGES) begin
							cur = 0;
							cnt = 0;
						end
					end
				end
				if (!hit) begin
					r.status = ST_NOFIT;
				end else begin
					for (k = 0; k < cnt; k++)
						page_taken[first + k] = 1'b1;
					run_len[first] = cnt;
					roving = (first + cnt >= HEAP_PAGES) ? 0 : first + cnt;
					r.block_address = 32'((longint'(heap_base) + first) << PAGE_SHIFT);
					live_pages.push_back(first);
				end
			end
		end else begin
			lo = longint'(heap_base) << PAGE_SHIFT;
			hi = lo + (longint'(HEAP_PAGES) << PAGE_SHIFT);
			addr = w.free_address;
			if (addr < lo || addr >= hi || w.free_address[PAGE_SHIFT-1:0] != '0) begin
				r.status = ST_IGNORED;
			end else begin
				idx = int'((addr - lo) >> PAGE_SHIFT);
				if (run_len[idx] == 0) begin
					r.status = ST_IGNORED;
				end else begin
					for (k = 0; k < run_len[idx] && idx + k < HEAP_PAGES; k++)
						page_taken[idx + k] = 1'b0;
					run_len[idx] = 0;
				end
			end
		end
		return r;
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// sample at the rising edge: acceptance, prediction and checking
	always @(posedge clk) begin
		rsp_t want;
		req_taken <= arst_n && req_valid && !req_stall;
		if (arst_n && req_valid && !req_stall) begin
			awaited_results.push_back(allocator_result(req));
			request_backlog.pop_front();
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_results.size() == 0) begin
				note_mismatch("result word with nothing awaited", rsp.block_address, '0);
			end else begin
				want = awaited_results.pop_front();
				if (rsp.block_address !== want.block_address)
					note_mismatch("block_address", rsp.block_address, want.block_address);
				if (rsp.status !== want.status)
					note_mismatch("status", 32'(rsp.status), 32'(want.status));
			end
		end
	end

	// drive at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_taken) begin
				if (req_taken && !quiet && $urandom_range(0, 3) == 0)
					gap = $urandom_range(1, 6);
				launch = (request_backlog.size() != 0) && (gap == 0);
				if (gap != 0)
					gap--;
				req_valid <= launch;
				if (launch)
					req <= request_backlog[0];
			end
			if (stall_left != 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else begin
				rsp_stall <= 1'b0;
				if (!quiet && $urandom_range(0, 4) == 0)
					stall_left = $urandom_range(1, 6);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_next_fit_page_allocator failed");
			$finish;
		end
	end

	task automatic queue_request(input logic kind, input logic [31:0] size,
			input logic [31:0] addr);
		req_t w;
		w.req_type = kind;
		w.size_bytes = (kind == REQ_ALLOC) ? size : $urandom();
		w.free_address = (kind == REQ_FREE) ? addr : $urandom();
		while (request_backlog.size() >= 3)
			@(negedge clk);
		request_backlog.push_back(w);
	endtask

	task automatic settle();
		while (request_backlog.size() != 0 || awaited_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_heap_base(input logic [BASE_W-1:0] pg);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = pg;
		@(negedge clk);
		cfg_we = 1'b0;
		heap_base = pg;
	endtask

	task automatic random_request();
		int unsigned pick, pages, slot, pg;
		logic [31:0] a;
		bit          spoil;
		pick = $urandom_range(0, 99);
		if (pick < 50 || (live_pages.size() == 0 && pick < 85)) begin
			case ($urandom_range(0, 19))
				15, 16, 17: pages = $urandom_range(25, 300);
				18:         pages = $urandom_range(301, 2048);
				19:         pages = $urandom_range(2049, HEAP_PAGES);
				default:    pages = $urandom_range(1, 24);
			endcase
			queue_request(REQ_ALLOC, (pages - 1) * 4096 + $urandom_range(1, 4096), '0);
		end else if (pick < 85) begin
			slot = $urandom_range(0, live_pages.size() - 1);
			pg = live_pages[slot];
			a = 32'((longint'(heap_base) + pg) << PAGE_SHIFT);
			spoil = ($urandom_range(0, 7) == 0);
			if (spoil)
				a = a + (($urandom_range(0, 1) == 0) ? $urandom_range(1, 4095) : 4096);
			// a wrapped address falls below the heap and is refused; keep the block for later
			if (!spoil && longint'(heap_base) + pg < (longint'(1) << BASE_W))
				live_pages.delete(slot);
			queue_request(REQ_FREE, '0, a);
		end else begin
			case ($urandom_range(0, 3))
				0: queue_request(REQ_ALLOC, '0, '0);
				1: queue_request(REQ_ALLOC, $urandom(), '0);
				2: queue_request(REQ_FREE, '0, $urandom());
				default: queue_request(REQ_FREE, '0,
					32'((longint'(heap_base) + $urandom_range(0, HEAP_PAGES - 1)) << PAGE_SHIFT));
			endcase
		end
	endtask

	initial begin
		logic [BASE_W-1:0] bases [5];
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		set_heap_base('0);

		// directed words on a base of zero
		queue_request(REQ_ALLOC, 32'h0, '0);
		queue_request(REQ_ALLOC, 32'hFFFF_FFFF, '0);
		queue_request(REQ_ALLOC, 32'h0100_0001, '0);
		queue_request(REQ_ALLOC, 32'h0100_0000, '0);   // whole heap, pointer wraps
		queue_request(REQ_ALLOC, 32'h1, '0);           // full lap, nothing free
		queue_request(REQ_FREE, '0, 32'h0);            // address zero is the first page
		queue_request(REQ_ALLOC, 32'h1, '0);
		queue_request(REQ_ALLOC, 32'h1000, '0);
		queue_request(REQ_ALLOC, 32'h1001, '0);
		queue_request(REQ_FREE, '0, 32'h3000);         // inside a run
		queue_request(REQ_FREE, '0, 32'h2001);
		queue_request(REQ_FREE, '0, 32'h0100_0000);    // one past the top
		queue_request(REQ_FREE, '0, 32'h1000);
		queue_request(REQ_FREE, '0, 32'h1000);         // double release
		queue_request(REQ_ALLOC, 32'h00FF_8000, '0);
		queue_request(REQ_FREE, '0, 32'h0);
		queue_request(REQ_ALLOC, 32'h6000, '0);        // run broken by the wrap
		queue_request(REQ_ALLOC, 32'h4000, '0);        // ends on the last page
		queue_request(REQ_ALLOC, 32'h2000, '0);
		queue_request(REQ_FREE, '0, 32'h2000);
		queue_request(REQ_FREE, '0, 32'h4000);
		queue_request(REQ_FREE, '0, 32'h00FF_C000);
		queue_request(REQ_FREE, '0, 32'h0);
		settle();
		live_pages.delete();

		bases[0] = '1;
		bases[1] = BASE_W'($urandom_range(1, 20'hFFFFE));
		bases[2] = 20'hFFC00;
		bases[3] = BASE_W'($urandom());
		bases[4] = '0;
		for (int ph = 0; ph < 5; ph++) begin
			quiet = (ph == 4);
			set_heap_base(bases[ph]);
			repeat (24) random_request();
			settle();
		end

		if (errors == 0)
			$display("tb_next_fit_page_allocator passed");
		else
			$display("tb_next_fit_page_allocator failed");
		$finish;
	end

endmodule
